// ===== rtl/core/mrf_pkg.sv =====
// shared types, codes and crc helper for the modbus rtu request framer
package mrf_pkg;

  localparam int FRAME_LEN = 8;
  localparam int CRC_SPAN  = 6;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // request selector codes
  localparam logic [1:0] REQ_READ_COILS = 2'd0;
  localparam logic [1:0] REQ_READ_HOLD  = 2'd1;
  localparam logic [1:0] REQ_WRITE_COIL = 2'd2;
  localparam logic [1:0] REQ_WRITE_REG  = 2'd3;

  // function codes on the wire
  localparam logic [7:0] FN_READ_COILS = 8'h01;
  localparam logic [7:0] FN_READ_HOLD  = 8'h03;
  localparam logic [7:0] FN_WRITE_COIL = 8'h05;
  localparam logic [7:0] FN_WRITE_REG  = 8'h06;

  localparam logic [7:0] COIL_ON_HI = 8'hFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  unit_id;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } res_t;

  typedef logic [CRC_SPAN-1:0][7:0] hdr_t;

  typedef struct packed {
    hdr_t        hdr;
    logic [15:0] crc;
  } pipe_t;

  function automatic logic [7:0] fn_code(input logic [1:0] sel);
    logic [7:0] code;
    unique case (sel)
      REQ_READ_COILS: code = FN_READ_COILS;
      REQ_READ_HOLD:  code = FN_READ_HOLD;
      REQ_WRITE_COIL: code = FN_WRITE_COIL;
      REQ_WRITE_REG:  code = FN_WRITE_REG;
      default:        code = FN_READ_COILS;
    endcase
    return code;
  endfunction

  // one byte of crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] acc_in, input logic [7:0] data);
    logic [15:0] acc;
    acc = acc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

// ===== rtl/core/modbus_rtu_request_framer_top.sv =====
// top level of the modbus rtu request framer
// A request is taken at a clock edge with start high and busy low. Its
// eight frame bytes (slave, function, address hi/lo, value hi/lo, crc
// lo/hi) come out on consecutive cycles, each marked by strobe for
// one cycle, the first one after the build, crc and serializer registers;
// last_byte marks the crc high byte. The crc is computed in a six-stage
// pipeline, one frame byte per stage, behind a header-building stage.
// The byte-wide result port sets the rate: busy stays high after each
// accept until the spacing counter runs out, and no request is taken then.
// Results cannot be held off; the receiver must take every byte as shown.
module modbus_rtu_request_framer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mrf_pkg::req_t req,
  output logic          strobe,
  output mrf_pkg::res_t result
);
  import mrf_pkg::*;

  logic       accept;
  logic [2:0] gap;

  logic  stage_valid [0:CRC_SPAN];
  pipe_t stage_pipe  [0:CRC_SPAN];

  assign accept = start && !busy;
  assign busy   = (gap != 3'd0);

  // spacing counter: loaded from the frame length on accept, busy while nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 3'd0;
    end else if (accept) begin
      gap <= 3'(FRAME_LEN - 1);
    end else if (gap != 3'd0) begin
      gap <= gap - 3'd1;
    end
  end

  mrf_build u_build (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .req       (req),
    .out_valid (stage_valid[0]),
    .out_pipe  (stage_pipe[0])
  );

  for (genvar k = 0; k < CRC_SPAN; k++) begin : g_crc
    mrf_crc_stage #(
      .IDX (k)
    ) u_crc (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_pipe   (stage_pipe[k]),
      .out_valid (stage_valid[k+1]),
      .out_pipe  (stage_pipe[k+1])
    );
  end

  mrf_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[CRC_SPAN]),
    .in_pipe  (stage_pipe[CRC_SPAN]),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

// ===== rtl/core/mrf_build.sv =====
// first pipeline stage: lays out the six header bytes of the frame
module mrf_build (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  mrf_pkg::req_t req,
  output logic          out_valid,
  output mrf_pkg::pipe_t out_pipe
);
  import mrf_pkg::*;

  hdr_t hdr_next;

  always_comb begin
    hdr_next[0] = req.unit_id;
    hdr_next[1] = fn_code(req.req_type);
    hdr_next[2] = req.reg_address[15:8];
    hdr_next[3] = req.reg_address[7:0];
    if (req.req_type == REQ_WRITE_COIL) begin
      // coil write: any nonzero value means on
      hdr_next[4] = (req.reg_value != 16'h0000) ? COIL_ON_HI : 8'h00;
      hdr_next[5] = 8'h00;
    end else begin
      hdr_next[4] = req.reg_value[15:8];
      hdr_next[5] = req.reg_value[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pipe.hdr <= hdr_next;
    out_pipe.crc <= CRC_INIT;
  end

endmodule

// ===== rtl/core/mrf_crc_stage.sv =====
// one crc pipeline stage: folds one header byte into the running crc
module mrf_crc_stage #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mrf_pkg::pipe_t in_pipe,
  output logic           out_valid,
  output mrf_pkg::pipe_t out_pipe
);
  import mrf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pipe.hdr <= in_pipe.hdr;
    out_pipe.crc <= crc_byte(in_pipe.crc, in_pipe.hdr[IDX]);
  end

endmodule

// ===== rtl/core/mrf_serializer.sv =====
// output stage: sends the eight frame bytes on consecutive cycles
module mrf_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mrf_pkg::pipe_t in_pipe,
  output logic           strobe,
  output mrf_pkg::res_t  result
);
  import mrf_pkg::*;

  logic [FRAME_LEN-1:0][7:0] bytes;
  logic [2:0]                cnt;
  logic                      active;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      active <= 1'b0;
      cnt    <= 3'd0;
    end else if (in_valid) begin
      strobe <= 1'b1;
      active <= 1'b1;
      cnt    <= 3'd1;
    end else if (active) begin
      strobe <= 1'b1;
      active <= (cnt != 3'(FRAME_LEN - 1));
      cnt    <= cnt + 3'd1;
    end else begin
      strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      bytes[CRC_SPAN-1:0] <= in_pipe.hdr;
      bytes[CRC_SPAN]     <= in_pipe.crc[7:0];
      bytes[CRC_SPAN+1]   <= in_pipe.crc[15:8];
      result.frame_byte   <= in_pipe.hdr[0];
      result.last_byte    <= 1'b0;
    end else begin
      result.frame_byte   <= bytes[cnt];
      result.last_byte    <= (cnt == 3'(FRAME_LEN - 1));
    end
  end

endmodule

// ===== rtl/core/mrf_checker.sv =====
// port-level checker for the framer, bound to the top level
module mrf_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input mrf_pkg::res_t result,
  input logic          strobe
);
  import mrf_pkg::*;

  // an accepted item raises busy to block the next one, and busy is released again afterwards
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_busy_released: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 !busy)
    else $error("busy still high one frame after accept");

  // a frame goes out without gaps up to its last byte
  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_byte) |=> strobe)
    else $error("gap inside a frame");

  a_last_after_seven: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_byte) |-> ($past(strobe, 7) && !$past(result.last_byte, 1)))
    else $error("last byte without a full frame before it");

endmodule

bind modbus_rtu_request_framer_top mrf_checker u_mrf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .strobe (strobe)
);

// ===== tb/sv/modbus_rtu_request_framer_top_test.sv =====
// self-checking testbench for the modbus rtu request framer: predicted frames vs. emitted bytes
module modbus_rtu_request_framer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mrf_pkg::*;

  // expected frame bytes, filled per accepted request and drained per strobe
  class frame_ledger;
    res_t pending_bytes[$];
    int errors;
    int reported;

    function new();
      errors = 0;
      reported = 0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void log_error(input string msg);
      errors++;
      if (reported < 10) begin
        reported++;
        $display("mismatch @%0t: %s", $realtime, msg);
      end
    endfunction

    function void note_request(input req_t r);
      logic [FRAME_LEN-1:0][7:0] frame;
      logic [15:0] crc;
      res_t item;
      int n;
      int b;
      frame[0] = r.unit_id;
      case (r.req_type)
        REQ_READ_COILS: frame[1] = FN_READ_COILS;
        REQ_READ_HOLD:  frame[1] = FN_READ_HOLD;
        REQ_WRITE_COIL: frame[1] = FN_WRITE_COIL;
        REQ_WRITE_REG:  frame[1] = FN_WRITE_REG;
        default:        frame[1] = 8'hxx;
      endcase
      frame[2] = r.reg_address[15:8];
      frame[3] = r.reg_address[7:0];
      if (r.req_type == REQ_WRITE_COIL) begin
        // any nonzero value turns the coil on
        frame[4] = (r.reg_value != 16'h0000) ? COIL_ON_HI : 8'h00;
        frame[5] = 8'h00;
      end else begin
        frame[4] = r.reg_value[15:8];
        frame[5] = r.reg_value[7:0];
      end
      crc = CRC_INIT;
      for (n = 0; n < CRC_SPAN; n++) begin
        crc = crc ^ {8'h00, frame[n]};
        for (b = 0; b < 8; b++) begin
          if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
          else crc = crc >> 1;
        end
      end
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (n = 0; n < FRAME_LEN; n++) begin
        item.frame_byte = frame[n];
        item.last_byte = (n == FRAME_LEN - 1);
        pending_bytes.push_back(item);
      end
    endfunction

    function void check_byte(input res_t got);
      res_t want;
      if (pending_bytes.size() == 0) begin
        log_error($sformatf("unexpected item frame_byte %02h last_byte %0b",
                            got.frame_byte, got.last_byte));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte)
        log_error($sformatf("frame_byte exp %02h got %02h, last_byte exp %0b got %0b",
                            want.frame_byte, got.frame_byte,
                            want.last_byte, got.last_byte));
    endfunction

    function void flag_leftover();
      if (pending_bytes.size() != 0)
        log_error($sformatf("%0d frame bytes never emitted", pending_bytes.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic strobe;
  req_t req = '0;
  res_t result;

  frame_ledger ledger;
  req_t directed_reqs[$];

  modbus_rtu_request_framer_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // all values sampled here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) ledger.note_request(req);
      if (strobe) ledger.check_byte(result);
    end
  end

  function automatic req_t make_req(input logic [1:0] sel, input logic [7:0] dev,
                                    input logic [15:0] addr, input logic [15:0] val);
    req_t r;
    r.req_type = sel;
    r.unit_id = dev;
    r.reg_address = addr;
    r.reg_value = val;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    logic [31:0] bits;
    bits = $urandom;
    r.req_type = bits[1:0];
    r.unit_id = bits[15:8];
    bits = $urandom;
    r.reg_address = bits[15:0];
    case ($urandom_range(0, 7))
      0: r.reg_value = 16'h0000;
      1: r.reg_value = 16'hFFFF;
      2: r.reg_value = {9'h000, bits[30:24]};  // typical small quantity
      default: r.reg_value = bits[31:16];
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 70) return $urandom_range(1, 4);
    if (roll < 92) return $urandom_range(6, 14);  // lands on every phase of a frame
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(input req_t r);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // n must be nonzero; req carries noise while start is low
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) begin
      @(posedge clk);
      req <= random_req();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int gap;
    int burst_left;
    ledger = new();
    burst_left = 0;

    directed_reqs.push_back(make_req(REQ_READ_COILS, 8'h01, 16'h0000, 16'h0001));
    directed_reqs.push_back(make_req(REQ_READ_COILS, 8'hFF, 16'hFFFF, 16'hFFFF));
    directed_reqs.push_back(make_req(REQ_READ_COILS, 8'h00, 16'h0013, 16'h0000));
    directed_reqs.push_back(make_req(REQ_READ_HOLD, 8'h11, 16'h006B, 16'h0003));
    directed_reqs.push_back(make_req(REQ_READ_HOLD, 8'h00, 16'hFFFF, 16'h0000));
    directed_reqs.push_back(make_req(REQ_READ_HOLD, 8'hFF, 16'h0000, 16'hFFFF));
    directed_reqs.push_back(make_req(REQ_READ_HOLD, 8'h5A, 16'hA5A5, 16'h5A5A));
    directed_reqs.push_back(make_req(REQ_WRITE_COIL, 8'h11, 16'h00AC, 16'h0000));
    directed_reqs.push_back(make_req(REQ_WRITE_COIL, 8'h11, 16'h00AC, 16'h0001));
    directed_reqs.push_back(make_req(REQ_WRITE_COIL, 8'hFF, 16'hFFFF, 16'hFFFF));
    directed_reqs.push_back(make_req(REQ_WRITE_COIL, 8'h00, 16'h0000, 16'h8000));
    directed_reqs.push_back(make_req(REQ_WRITE_COIL, 8'h7E, 16'h1234, 16'hFF00));
    directed_reqs.push_back(make_req(REQ_WRITE_REG, 8'h11, 16'h0001, 16'h0003));
    directed_reqs.push_back(make_req(REQ_WRITE_REG, 8'h00, 16'h0000, 16'h0000));
    directed_reqs.push_back(make_req(REQ_WRITE_REG, 8'hFF, 16'hFFFF, 16'hFFFF));
    directed_reqs.push_back(make_req(REQ_WRITE_REG, 8'hA5, 16'h5A5A, 16'hA5A5));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_reqs[i]) begin
      send_req(directed_reqs[i]);
      if (i % 5 == 4) idle_cycles($urandom_range(1, 12));
    end
    // hold off until the pipeline is empty
    drain();

    for (int k = 0; k < 200; k++) begin
      send_req(random_req());
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
        gap = pick_gap();
      end
      if ($urandom_range(0, 39) == 0) drain();
      else if (gap > 0) idle_cycles(gap);
    end

    drain();
    repeat (24) @(posedge clk);
    ledger.flag_leftover();
    if (ledger.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
